// File: sv/cts_pkg.sv
// cts_pkg: shared types and codes for the character transliterate/squash core.
// Used by cts_front, cts_queue, cts_back and char_transliterate_squash_core.
`default_nettype none

package cts_pkg;

    localparam int LEN_W   = 7;   // width of src_len / dst_len registers
    localparam int SLOT_W  = 6;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 8;   // holds any table index up to 256 entries
    localparam int CMP_W   = 9;   // compare width for lengths, indexes and depths
    localparam int CFG_IDX_W = 2;
    localparam int Q_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_LOAD_SRC = 2'd0,
        CMD_LOAD_DST = 2'd1,
        CMD_DATA     = 2'd2,
        CMD_EOS      = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COMPLEMENT = 2'd0,
        REG_SRC_LEN    = 2'd1,
        REG_DST_LEN    = 2'd2
    } cfg_reg_t;

    // Effective configuration, lengths already clamped to the table depths
    typedef struct packed {
        logic             complement;
        logic [LEN_W-1:0] sl;
        logic [LEN_W-1:0] dl;
    } cfg_t;

    // One classified beat as it travels from front to back
    typedef struct packed {
        cmd_t              cmd;
        logic [SLOT_W-1:0] slot;
        logic [BYTE_W-1:0] value;
        logic              hit;
        logic [IDX_W-1:0]  idx;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// File: sv/cts_front.sv
// cts_front: source character table and first-match classification of each beat.
// Depends on cts_pkg.
`default_nettype none

module cts_front
    import cts_pkg::*;
#(
    parameter int SRC_DEPTH = 64
) (
    input  wire logic              aclk,
    input  wire logic              accept,
    input  wire cmd_t              cmd,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire logic [BYTE_W-1:0] value,
    input  wire cfg_t              cfg,
    output item_t                  item
);

    localparam int SRC_AW = (SRC_DEPTH > 1) ? $clog2(SRC_DEPTH) : 1;

    logic [BYTE_W-1:0]    src_tab [SRC_DEPTH];
    logic [SRC_DEPTH-1:0] match_vec;
    logic [CMP_W-1:0]     slot_ext;
    logic [CMP_W-1:0]     sl_ext;
    logic [IDX_W-1:0]     idx;

    assign slot_ext = CMP_W'(slot);
    assign sl_ext   = CMP_W'(cfg.sl);

    always_ff @(posedge aclk) begin
        if (accept && cmd == CMD_LOAD_SRC && slot_ext < CMP_W'(SRC_DEPTH)) begin
            src_tab[slot_ext[SRC_AW-1:0]] <= value;
        end
    end

    // Entries at or beyond the active source length never match
    always_comb begin
        for (int k = 0; k < SRC_DEPTH; k++) begin
            match_vec[k] = (src_tab[k] == value) && (CMP_W'(k) < sl_ext);
        end
    end

    // Lowest matching index wins
    always_comb begin
        idx = '0;
        for (int k = SRC_DEPTH - 1; k >= 0; k--) begin
            if (match_vec[k]) begin
                idx = IDX_W'(k);
            end
        end
    end

    always_comb begin
        item.cmd   = cmd;
        item.slot  = slot;
        item.value = value;
        item.hit   = |match_vec;
        item.idx   = idx;
    end

endmodule

`default_nettype wire

// File: sv/cts_queue.sv
// cts_queue: two-entry FIFO of classified beats between front and back.
// Depends on cts_pkg.
`default_nettype none

module cts_queue
    import cts_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire item_t push_item,
    input  wire logic  pop,
    output item_t      pop_item,
    output q_status_t  status
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    item_t              q_mem [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item     = q_mem[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(Q_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

// File: sv/cts_back.sv
// cts_back: destination table, squash run tracking and the output register.
// Depends on cts_pkg; fed by cts_queue.
`default_nettype none

module cts_back
    import cts_pkg::*;
#(
    parameter int DST_DEPTH = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire item_t             item,
    input  wire logic              item_valid,
    output logic                   item_pop,
    input  wire cfg_t              cfg,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [BYTE_W-1:0]      m_tdata
);

    localparam int DST_AW = (DST_DEPTH > 1) ? $clog2(DST_DEPTH) : 1;

    logic [BYTE_W-1:0] dst_mem [DST_DEPTH];

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              use_dest_reg;
    logic [BYTE_W-1:0] lit_reg;
    logic [BYTE_W-1:0] rd_reg;
    logic              run_reg;
    logic              run_next;

    logic              advance;
    logic              produce;
    logic              use_dest;
    logic [CMP_W-1:0]  addr;
    logic [CMP_W-1:0]  sl_ext;
    logic [CMP_W-1:0]  dl_ext;
    logic [CMP_W-1:0]  last_ext;
    logic [CMP_W-1:0]  i_ext;
    logic [CMP_W-1:0]  slot_ext;
    logic              i_valid;
    logic              squash_mode;

    assign advance  = !out_valid_reg || m_tready;
    assign item_pop = item_valid && advance;

    assign sl_ext   = CMP_W'(cfg.sl);
    assign dl_ext   = CMP_W'(cfg.dl);
    assign last_ext = dl_ext - CMP_W'(1);
    assign slot_ext = CMP_W'(item.slot);

    // In complement mode the non-members are the ones acted on, at index dl
    assign i_valid     = cfg.complement ? !item.hit : item.hit;
    assign i_ext       = cfg.complement ? dl_ext : CMP_W'(item.idx);
    assign squash_mode = (sl_ext > dl_ext) || cfg.complement;

    always_comb begin
        produce  = 1'b0;
        use_dest = 1'b0;
        addr     = '0;
        run_next = run_reg;
        unique case (item.cmd) inside
            CMD_LOAD_SRC, CMD_LOAD_DST: begin
            end
            CMD_EOS: begin
                run_next = 1'b0;
            end
            CMD_DATA: begin
                if (cfg.dl == '0) begin
                    run_next = 1'b0;
                    produce  = !i_valid;
                end else if (squash_mode && i_valid && i_ext >= last_ext) begin
                    // one copy of the last destination byte per run
                    if (!run_reg) begin
                        produce  = 1'b1;
                        use_dest = 1'b1;
                        addr     = last_ext;
                    end
                    run_next = 1'b1;
                end else begin
                    run_next = 1'b0;
                    produce  = 1'b1;
                    if (i_valid && i_ext < dl_ext) begin
                        use_dest = 1'b1;
                        addr     = i_ext;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = item_pop && produce;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            run_reg       <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (item_pop) begin
                run_reg <= run_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_pop) begin
            use_dest_reg <= use_dest;
            lit_reg      <= item.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_pop && item.cmd == CMD_LOAD_DST && slot_ext < CMP_W'(DST_DEPTH)) begin
            dst_mem[slot_ext[DST_AW-1:0]] <= item.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_pop && use_dest) begin
            rd_reg <= dst_mem[addr[DST_AW-1:0]];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = use_dest_reg ? rd_reg : lit_reg;

endmodule

`default_nettype wire

// File: sv/char_transliterate_squash_core.sv
// char_transliterate_squash_core: top level of the byte-stream transliterator.
// Depends on cts_pkg, cts_front, cts_queue and cts_back.
//
// Usage:
//   s_ channel: one beat per command. s_tuser carries cmd (load source entry,
//   load destination entry, data byte, end of stream); s_tdata carries slot
//   and value. Loads fill the tables, data beats are translated, deleted or
//   squashed, end of stream closes any squash run.
//   m_ channel: one beat per emitted byte; loads, end of stream, deleted and
//   squashed bytes give no beat.
//   cfg_ channel: writes complement, src_len and dst_len; write only while
//   the core is idle. cfg_ready is always high.
// Timing: one beat accepted per cycle, sustained while m_tready is high. A byte
//   accepted goes through a queue slot and then the output register to m_tdata;
//   the source compare and first-match search finish in the accept cycle.
// Reset: synchronous, active low; clears the queue, the output register,
//   the squash run flag and the configuration. Tables are not cleared.
// Stall: with m_tready low the output register holds, the two-entry queue
//   fills and then s_tready drops.
`default_nettype none

module char_transliterate_squash_core
    import cts_pkg::*;
#(
    parameter int SRC_DEPTH = 64,
    parameter int DST_DEPTH = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [15:0]          s_tdata,   // [5:0] slot, [13:6] value, [15:14] zero
    input  wire logic [1:0]           s_tuser,   // [1:0] cmd
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [BYTE_W-1:0]         m_tdata,   // [7:0] out_byte
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LEN_W-1:0]     cfg_data
);

    logic             complement_reg;
    logic [LEN_W-1:0] src_len_reg;
    logic [LEN_W-1:0] dst_len_reg;
    cfg_t             cfg;

    logic             s_accept;
    item_t            front_item;
    item_t            q_item;
    logic             q_pop;
    q_status_t        q_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            complement_reg <= 1'b0;
            src_len_reg    <= '0;
            dst_len_reg    <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_COMPLEMENT: complement_reg <= cfg_data[0];
                REG_SRC_LEN:    src_len_reg    <= cfg_data;
                REG_DST_LEN:    dst_len_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Lengths beyond the table depth act as the depth
    always_comb begin
        cfg.complement = complement_reg;
        cfg.sl = (CMP_W'(src_len_reg) > CMP_W'(SRC_DEPTH)) ? LEN_W'(SRC_DEPTH) : src_len_reg;
        cfg.dl = (CMP_W'(dst_len_reg) > CMP_W'(DST_DEPTH)) ? LEN_W'(DST_DEPTH) : dst_len_reg;
    end

    assign s_tready = !q_status.full;
    assign s_accept = s_tvalid && s_tready;

    cts_front #(
        .SRC_DEPTH (SRC_DEPTH)
    ) u_front (
        .aclk   (aclk),
        .accept (s_accept),
        .cmd    (cmd_t'(s_tuser)),
        .slot   (s_tdata[SLOT_W-1:0]),
        .value  (s_tdata[SLOT_W+BYTE_W-1:SLOT_W]),
        .cfg    (cfg),
        .item   (front_item)
    );

    cts_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_accept),
        .push_item (front_item),
        .pop       (q_pop),
        .pop_item  (q_item),
        .status    (q_status)
    );

    cts_back #(
        .DST_DEPTH (DST_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item       (q_item),
        .item_valid (!q_status.empty),
        .item_pop   (q_pop),
        .cfg        (cfg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // Queue never written while full, never read while empty
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> !q_status.full)
        else $error("beat pushed into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("beat popped from empty queue");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && q_status.empty)
        else $error("output or queue not cleared by reset");

endmodule

`default_nettype wire

// File: test/cts_stream_checker.sv
`timescale 1ns / 100ps
// cts_stream_checker: watches the cfg_, s_ and m_ channels of char_transliterate_squash_core,
// predicts every output byte from its own copy of the tables and registers, and compares.
// Depends on cts_pkg for the command and register codes.
module cts_stream_checker
    import cts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // [5:0] slot, [13:6] value, [15:14] zero
    input  logic [1:0]  s_tuser,    // [1:0] cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,    // [7:0] out_byte
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    output int          fail_count,
    output int          pending
);
    localparam int TBL_DEPTH = 64;

    logic [7:0] src_chars [TBL_DEPTH];
    logic [7:0] dst_chars [TBL_DEPTH];
    logic       run_open;
    logic       cfg_compl;
    logic [6:0] cfg_src_len;
    logic [6:0] cfg_dst_len;
    logic [7:0] expected_bytes [$];
    int         fails = 0;

    // Translate one data byte; returns 1 when it yields an output beat.
    function automatic bit xlat_byte(input logic [7:0] v, output logic [7:0] ob);
        int  sl;
        int  dl;
        int  hit;
        int  idx;
        int  last;
        bit  squashing;
        sl = (cfg_src_len > TBL_DEPTH) ? TBL_DEPTH : int'(cfg_src_len);
        dl = (cfg_dst_len > TBL_DEPTH) ? TBL_DEPTH : int'(cfg_dst_len);
        ob = v;
        hit = -1;
        for (int k = 0; k < sl; k++)
            if (hit < 0 && src_chars[k] == v) hit = k;
        if (cfg_compl) idx = (hit >= 0) ? -1 : dl;
        else idx = hit;

        if (dl == 0) begin
            // delete mode
            run_open = 1'b0;
            return (idx < 0);
        end

        last = dl - 1;
        squashing = (sl > dl) || cfg_compl;
        if (squashing && idx >= last) begin
            if (run_open) return 1'b0;
            run_open = 1'b1;
            ob = dst_chars[last];
            return 1'b1;
        end
        run_open = 1'b0;
        if (idx >= 0 && idx < dl) ob = dst_chars[idx];
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        logic [7:0] ob;
        logic [7:0] want;
        if (!aresetn) begin
            run_open = 1'b0;
            cfg_compl = 1'b0;
            cfg_src_len = '0;
            cfg_dst_len = '0;
            expected_bytes.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected output beat, expected none, got %02h",
                             $time, m_tdata);
                    fails++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want) begin
                        $display("%0t: out_byte mismatch, expected %02h, got %02h",
                                 $time, want, m_tdata);
                        fails++;
                    end
                end
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_COMPLEMENT: cfg_compl = cfg_data[0];
                    REG_SRC_LEN:    cfg_src_len = cfg_data;
                    REG_DST_LEN:    cfg_dst_len = cfg_data;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                case (cmd_t'(s_tuser))
                    CMD_LOAD_SRC: src_chars[s_tdata[5:0]] = s_tdata[13:6];
                    CMD_LOAD_DST: dst_chars[s_tdata[5:0]] = s_tdata[13:6];
                    CMD_DATA:     if (xlat_byte(s_tdata[13:6], ob)) expected_bytes.push_back(ob);
                    CMD_EOS:      run_open = 1'b0;
                    default: ;
                endcase
            end
        end
        pending <= expected_bytes.size();
        fail_count <= fails;
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// testbench: clock, reset, stimulus and verdict for char_transliterate_squash_core.
// Prediction and comparison live in cts_stream_checker; depends on cts_pkg.
module testbench;
    import cts_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int TBL_DEPTH    = 64;
    localparam int HOLD_CYCLES  = 300;
    localparam int NUM_PHASES   = 9;
    localparam int PHASE_BEATS  = 150;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = CMD_LOAD_SRC;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_COMPLEMENT;
    logic [6:0]  cfg_data = '0;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 30;
    bit hold_arm = 1'b0;
    bit hold_used = 1'b0;
    int hold_left = 0;
    int cycles = 0;

    // stimulus-side view of the tables, used to pick matching bytes and to skip loaded entries
    logic [7:0] src_vals [TBL_DEPTH];
    bit         src_loaded [TBL_DEPTH];
    bit         dst_loaded [TBL_DEPTH];
    logic [7:0] last_byte = '0;

    // per-phase settings: extremes, delete mode, complement, lengths past the depth
    bit ph_compl [NUM_PHASES] = '{0, 1, 0, 1, 0, 1, 0, 0, 0};
    int ph_sl    [NUM_PHASES] = '{64, 5, 10, 64, 127, 0, 6, 0, 0};
    int ph_dl    [NUM_PHASES] = '{0, 0, 6, 64, 127, 3, 10, 0, 0};

    char_transliterate_squash_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cts_stream_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random backpressure, plus one long hold so the core backs up
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_arm && !hold_used) begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [7:0] rand_char();
        // half from a small alphabet so duplicates and first-match cases show up
        if ($urandom_range(1)) return 8'($urandom_range(255));
        return 8'(8'h61 + $urandom_range(7));
    endfunction

    // Valid stays high across back-to-back beats; it only drops on an idle cycle.
    task automatic send_beat(input cmd_t c, input logic [5:0] slot, input logic [7:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= c;
        s_tdata <= {2'b00, v, slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (c == CMD_LOAD_SRC) begin
            src_vals[slot] = v;
            src_loaded[slot] = 1'b1;
        end
        if (c == CMD_LOAD_DST) dst_loaded[slot] = 1'b1;
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [6:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_config(input logic c, input logic [6:0] sl, input logic [6:0] dl);
        write_reg(REG_COMPLEMENT, {6'd0, c});
        write_reg(REG_SRC_LEN, sl);
        write_reg(REG_DST_LEN, dl);
        cfg_valid <= 1'b0;
    endtask

    // wait for every expected byte, then let beats that give none settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // load every table entry the current lengths will read
    task automatic fill_tables(input int sl, input int dl);
        for (int k = 0; k < TBL_DEPTH; k++) begin
            if (k < sl && !src_loaded[k]) send_beat(CMD_LOAD_SRC, 6'(k), rand_char());
            if (k < dl && !dst_loaded[k]) send_beat(CMD_LOAD_DST, 6'(k), rand_char());
        end
    endtask

    task automatic random_beat(input int sl);
        int         r;
        logic [7:0] v;
        r = $urandom_range(99);
        if (r < 10) begin
            send_beat(CMD_LOAD_SRC, 6'($urandom_range(63)), rand_char());
        end else if (r < 18) begin
            send_beat(CMD_LOAD_DST, 6'($urandom_range(63)), rand_char());
        end else if (r < 26) begin
            send_beat(CMD_EOS, 6'($urandom_range(63)), 8'($urandom_range(255)));
        end else begin
            r = $urandom_range(99);
            if (r < 45 && sl > 0) v = src_vals[$urandom_range(sl - 1)];
            else if (r < 70) v = last_byte;     // repeats build squash runs
            else v = 8'($urandom_range(255));
            last_byte = v;
            send_beat(CMD_DATA, 6'($urandom_range(63)), v);
        end
    endtask

    initial begin
        logic c;
        int   sl;
        int   dl;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: sl > dl so index 1 and up squash into dst[1]
        set_config(1'b0, 7'd3, 7'd2);
        send_beat(CMD_LOAD_SRC, 6'd0, 8'h61);
        send_beat(CMD_LOAD_SRC, 6'd1, 8'h00);
        send_beat(CMD_LOAD_SRC, 6'd2, 8'hFF);
        send_beat(CMD_LOAD_DST, 6'd0, 8'h41);
        send_beat(CMD_LOAD_DST, 6'd1, 8'h5A);
        send_beat(CMD_LOAD_SRC, 6'd63, 8'hFF);
        send_beat(CMD_LOAD_DST, 6'd63, 8'h00);
        send_beat(CMD_DATA, 6'd0, 8'h61);
        send_beat(CMD_DATA, 6'd63, 8'h00);
        send_beat(CMD_DATA, 6'd0, 8'hFF);
        send_beat(CMD_LOAD_SRC, 6'd5, 8'h33);   // a load inside a run keeps it open
        send_beat(CMD_DATA, 6'd0, 8'h00);
        send_beat(CMD_DATA, 6'd0, 8'h7E);       // copied byte closes the run
        send_beat(CMD_DATA, 6'd0, 8'hFF);
        send_beat(CMD_EOS, 6'd63, 8'hFF);
        send_beat(CMD_DATA, 6'd0, 8'hFF);
        send_beat(CMD_DATA, 6'd0, 8'h00);
        drain();
        // run still open across a register write; complement now squashes non-members
        set_config(1'b1, 7'd3, 7'd2);
        send_beat(CMD_DATA, 6'd0, 8'h99);
        send_beat(CMD_DATA, 6'd0, 8'h61);
        send_beat(CMD_DATA, 6'd0, 8'h99);
        send_beat(CMD_EOS, 6'd0, 8'h00);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 3) begin
                send_idle_pct = 21;
                recv_idle_pct = 74;
            end else if (p < 6) begin
                send_idle_pct = 74;
                recv_idle_pct = 21;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            c = ph_compl[p];
            sl = ph_sl[p];
            dl = ph_dl[p];
            if (p == NUM_PHASES - 1) begin
                c = 1'($urandom_range(1));
                sl = $urandom_range(127);
                dl = $urandom_range(127);
            end
            set_config(c, 7'(sl), 7'(dl));
            if (sl > TBL_DEPTH) sl = TBL_DEPTH;
            if (dl > TBL_DEPTH) dl = TBL_DEPTH;
            fill_tables(sl, dl);
            hold_arm = (p == 4);
            for (int n = 0; n < PHASE_BEATS; n++) random_beat(sl);
            drain();
        end

        if (fail_count == 0 && pending == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
sv/cts_pkg.sv
sv/cts_front.sv
sv/cts_queue.sv
sv/cts_back.sv
sv/char_transliterate_squash_core.sv
test/cts_stream_checker.sv
test/testbench.sv
